/* hdl/madc_pkg.sv */
package madc_pkg;

    // Window length and derived widths
    localparam int WINDOW   = 8;
    localparam int SAMPLE_W = 12;
    localparam int SUM_W    = $clog2((1 << SAMPLE_W) * WINDOW);
    localparam int CNT_W    = $clog2(WINDOW + 1);
    localparam int PTR_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int DIV_CNT_W = $clog2(SUM_W);

    // Duty mapping
    localparam int DUTY_W      = 7;
    localparam int PROD_W      = 19;
    localparam int FULL_SCALE  = 4095;
    localparam int DUTY_SCALE  = 100;
    localparam int DUTY_HIGH   = 80;

    // CRC-8
    localparam logic [7:0] CRC_POLY = 8'h07;

    // Stream widths
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 32;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;

    // One request handed from front to back
    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic [SUM_W-1:0]    sum;
        logic [CNT_W-1:0]    count;
    } madc_item_t;

    // Queue status
    typedef struct packed {
        logic empty;
        logic full;
    } madc_qstat_t;

    // One byte through the bitwise CRC-8
    function automatic logic [7:0] crc_byte(input logic [7:0] crc_in, input logic [7:0] data);
        logic [7:0] c;
        c = crc_in ^ data;
        for (int b = 0; b < 8; b++)
        begin
            if (c[7])
            begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

/* hdl/moving_average_duty_crc.sv */
// Channel | Dir | Width | Fields (low bit up)
// s_*     | in  | 16    | sample[11:0], zero pad
// m_*     | out | 32    | filtered[11:0], duty[18:12], high_drive[19], status_crc[27:20], pad
//
// Each request passes through the back end as one load, 15 steps of the
// bit-serial divider (sum by fill count), then multiply, duty map and CRC.
// The front updates window and running sum in the accept cycle; a two-deep
// queue lets it take requests while the back end is busy.
// Reset clears pointers, fill count, sum, queue and output valid.
// The output register holds a result until taken; the back end waits on it.
module moving_average_duty_crc
    import madc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // sample[11:0], pad
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata    // filtered, duty, high_drive, status_crc, pad
);

    madc_item_t  push_item;
    madc_item_t  pop_item;
    madc_qstat_t qstat;
    logic        push;
    logic        pop;

    assign s_tready = !qstat.full;
    assign push     = s_tvalid && s_tready;

    madc_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .sample (s_tdata[SAMPLE_W-1:0]),
        .item   (push_item)
    );

    madc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .stat      (qstat)
    );

    madc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .qstat    (qstat),
        .item     (pop_item),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

/* hdl/madc_front.sv */
module madc_front
    import madc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic [SAMPLE_W-1:0] sample,
    output madc_item_t          item
);

    logic [SAMPLE_W-1:0] win_reg [WINDOW];
    logic [PTR_W-1:0]    ptr_reg, ptr_next;
    logic [CNT_W-1:0]    fill_reg, fill_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic                full;

    assign full = (fill_reg == CNT_W'(WINDOW));

    // New sum and fill level for the incoming sample
    always_comb
    begin
        if (full)
        begin
            sum_next  = sum_reg - SUM_W'(win_reg[ptr_reg]) + SUM_W'(sample);
            fill_next = fill_reg;
        end
        else
        begin
            sum_next  = sum_reg + SUM_W'(sample);
            fill_next = fill_reg + CNT_W'(1);
        end
        if (ptr_reg == PTR_W'(WINDOW - 1))
        begin
            ptr_next = '0;
        end
        else
        begin
            ptr_next = ptr_reg + PTR_W'(1);
        end
    end

    assign item.sample = sample;
    assign item.sum    = sum_next;
    assign item.count  = fill_next;

    // Window control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg  <= '0;
            fill_reg <= '0;
            sum_reg  <= '0;
        end
        else if (push)
        begin
            ptr_reg  <= ptr_next;
            fill_reg <= fill_next;
            sum_reg  <= sum_next;
        end
    end

    // Sample window
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            win_reg[ptr_reg] <= sample;
        end
    end

endmodule

/* hdl/madc_queue.sv */
module madc_queue
    import madc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  madc_item_t  push_item,
    input  logic        pop,
    output madc_item_t  pop_item,
    output madc_qstat_t stat
);

    madc_item_t           mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]    wr_reg, rd_reg;
    logic [QPTR_W:0]      cnt_reg;

    assign stat.empty = (cnt_reg == '0);
    assign stat.full  = (cnt_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign pop_item   = mem[rd_reg];

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_reg <= rd_reg + QPTR_W'(1);
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + (QPTR_W+1)'(1);
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - (QPTR_W+1)'(1);
            end
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_reg] <= push_item;
        end
    end

endmodule

/* hdl/madc_back.sv */
module madc_back
    import madc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  madc_qstat_t           qstat,
    input  madc_item_t            item,
    output logic                  pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_DUTY = 3'd3;
    localparam logic [2:0] S_CRC  = 3'd4;

    logic [2:0]           state_reg, state_next;
    logic [DIV_CNT_W-1:0] step_reg;
    logic [SUM_W-1:0]     dvd_reg;
    logic [CNT_W-1:0]     rem_reg;
    logic [CNT_W-1:0]     dsr_reg;
    logic [7:0]           raw_lo_reg;
    logic [7:0]           crc_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [DUTY_W-1:0]    duty_reg;
    logic                 out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    logic [CNT_W:0]       trial;
    logic                 qbit;
    logic [SAMPLE_W-1:0]  filt;
    logic [DUTY_W-1:0]    dq;
    logic [12:0]          dr;
    logic [DUTY_W-1:0]    duty_calc;
    logic                 slot_free;
    logic [7:0]           crc_final;

    assign filt      = dvd_reg[SAMPLE_W-1:0];
    assign slot_free = !out_valid_reg || m_tready;
    assign pop       = (state_reg == S_IDLE) && !qstat.empty;

    // One restoring divide step
    assign trial = {rem_reg, dvd_reg[SUM_W-1]};
    assign qbit  = (trial >= {1'b0, dsr_reg});

    // Product / 4095 as (p >> 12) plus one correction
    assign dq = prod_reg[PROD_W-1:12];
    assign dr = {1'b0, prod_reg[11:0]} + 13'(dq);
    assign duty_calc = (dr >= 13'(FULL_SCALE)) ? dq + DUTY_W'(1) : dq;

    assign crc_final = crc_byte(crc_reg, filt[7:0]);

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (!qstat.empty)
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (step_reg == DIV_CNT_W'(SUM_W - 1))
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:  state_next = S_DUTY;
            S_DUTY: state_next = S_CRC;
            S_CRC:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_IDLE)
            begin
                step_reg <= '0;
            end
            else if (state_reg == S_DIV)
            begin
                step_reg <= step_reg + DIV_CNT_W'(1);
            end
            if (state_reg == S_CRC && slot_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                dvd_reg    <= item.sum;
                rem_reg    <= '0;
                dsr_reg    <= item.count;
                raw_lo_reg <= item.sample[7:0];
                crc_reg    <= crc_byte(8'h00, 8'(item.sample[SAMPLE_W-1:8]));
            end
            S_DIV:
            begin
                rem_reg <= qbit ? CNT_W'(trial - {1'b0, dsr_reg}) : CNT_W'(trial);
                dvd_reg <= {dvd_reg[SUM_W-2:0], qbit};
            end
            S_MUL:
            begin
                prod_reg <= PROD_W'(filt) * PROD_W'(DUTY_SCALE);
                crc_reg  <= crc_byte(crc_reg, raw_lo_reg);
            end
            S_DUTY:
            begin
                duty_reg <= duty_calc;
                crc_reg  <= crc_byte(crc_reg, 8'(duty_calc));
            end
            S_CRC:
            begin
                if (slot_free)
                begin
                    out_data_reg <= {4'b0, crc_final,
                                     (duty_reg > DUTY_W'(DUTY_HIGH)), duty_reg, filt};
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
